// File: sv/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // One stored entry, also the word handed from a cell to its neighbor.
    typedef struct packed {
        logic                         valid;
        logic signed [KEY_BITS-1:0]   key;
        logic signed [VALUE_BITS-1:0] value;
    } entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                       update;
        logic                       touch;
        logic                       evict;
        logic signed [KEY_BITS-1:0] key;
    } cell_ctl_t;

endpackage

// File: sv/lkvc_if.sv
`timescale 1ns / 1ps

interface lkvc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [lkvc_pkg::KEY_BITS-1:0]   key;
    logic signed [lkvc_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic signed [lkvc_pkg::VALUE_BITS-1:0] read_value;
    logic                                  evicted;

    modport source (output valid, output found, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    output ready);
endinterface

interface lkvc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lkvc_pkg::CAP_BITS-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lru_key_value_cache_top.sv
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement, built
// as a row of ENTRIES cells kept in recency order: cell 0 holds the most recent
// entry and live entries always fill cells 0 to count-1. Every request word is
// compared against all cells at once; a hit or an insert loads the head cell
// and shifts the younger cells one step down the row, so the least recent entry
// drops off the end of the live range on eviction. Each request is accepted,
// the row updates at that edge, and the response word appears registered on
// the next cycle. A new request is taken in the same cycle that the pending
// response is drained, so the block sustains one word per cycle while each
// response is taken at once; the single response register sets that limit.
// The capacity register (reset 16) is written through the cfg channel, which
// is always ready; a capacity of 0 acts as 1 and values above ENTRIES act as
// ENTRIES. Write it only while no request is outstanding.
module lru_key_value_cache_top (
    input  logic        clk,
    input  logic        rst_n,
    lkvc_req_if.sink    req,
    lkvc_rsp_if.source  rsp,
    lkvc_cfg_if.sink    cfg
);
    import lkvc_pkg::*;

    logic [CAP_BITS-1:0]          capacity_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;
    logic                         rsp_valid_reg;
    logic                         found_reg;
    logic signed [VALUE_BITS-1:0] read_value_reg;
    logic                         evicted_reg;

    logic                         accept;
    logic                         any_hit;
    logic                         full;
    logic [CNT_BITS-1:0]          eff_cap;
    logic signed [VALUE_BITS-1:0] hit_value;
    logic [ENTRIES-1:0]           hit_vec;
    logic [ENTRIES-1:0]           valid_vec;
    logic                         hit_chain [ENTRIES+1];
    entry_t                       chain     [ENTRIES+1];
    entry_t                       head;
    cell_ctl_t                    ctl;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Clamp capacity into 1..ENTRIES.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_BITS'(1);
        end
        else if (32'(capacity_reg) > 32'(ENTRIES))
        begin
            eff_cap = CNT_BITS'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_BITS'(capacity_reg);
        end
    end

    assign any_hit = hit_chain[0];
    assign full    = count_reg >= eff_cap;

    // Head word entering cell 0: the touched entry (new value on a put) or the
    // freshly inserted key.
    assign head.valid = 1'b1;
    assign head.key   = req.key;
    assign head.value = (req.cmd == CMD_PUT) ? req.value : hit_value;

    assign ctl.update = accept && (req.cmd == CMD_PUT || any_hit);
    assign ctl.touch  = any_hit;
    assign ctl.evict  = (req.cmd == CMD_PUT) && !any_hit && full;
    assign ctl.key    = req.key;

    assign chain[0]           = head;
    assign hit_chain[ENTRIES] = 1'b0;

    for (genvar j = 0; j < ENTRIES; j++)
    begin : g_cell
        lkvc_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .left          (chain[j]),
            .hit_right_in  (hit_chain[j+1]),
            .entry         (chain[j+1]),
            .hit           (hit_vec[j]),
            .hit_right_out (hit_chain[j])
        );
        assign valid_vec[j] = chain[j+1].valid;
    end

    // Keys are unique among live cells, so an OR of the gated values selects
    // the hit entry.
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_value = hit_value | chain[i+1].value;
            end
        end
    end

    // Grow only on an insert that does not replace the least recent entry.
    always_comb
    begin
        count_next = count_reg;
        if (accept && req.cmd == CMD_PUT && !any_hit && !full)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.data;
            end
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response word until it is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg      <= any_hit;
            read_value_reg <= (req.cmd == CMD_GET && any_hit) ? hit_value : '1;
            evicted_reg    <= ctl.evict;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.evicted    = evicted_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_vec))
        else $error("live count disagrees with cell valid bits");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}))
        else $error("live cells are not packed at the head of the row");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("key matched in more than one cell");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && evicted_reg |-> !found_reg)
        else $error("eviction reported on a hit");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

endmodule

// File: sv/lkvc_cell.sv
`timescale 1ns / 1ps

module lkvc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lkvc_pkg::cell_ctl_t ctl,
    input  lkvc_pkg::entry_t    left,
    input  logic                hit_right_in,
    output lkvc_pkg::entry_t    entry,
    output logic                hit,
    output logic                hit_right_out
);
    import lkvc_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [KEY_BITS-1:0]   key_reg;
    logic signed [KEY_BITS-1:0]   key_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;
    logic                         shift;

    assign hit           = valid_reg && (key_reg == ctl.key);
    assign hit_right_out = hit | hit_right_in;

    // Take the left neighbor's entry when this position moves one step older.
    always_comb
    begin
        if (ctl.touch)
        begin
            shift = ctl.update & hit_right_out;
        end
        else if (ctl.evict)
        begin
            shift = ctl.update & valid_reg;
        end
        else
        begin
            shift = ctl.update & left.valid;
        end
        valid_next = shift ? left.valid : valid_reg;
        key_next   = shift ? left.key   : key_reg;
        value_next = shift ? left.value : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule
